// File: src/pvpd_pkg.sv
// Shared types, constants and colour functions for the planar video pixel decoder.
// Used by every module of the decoder; depends on nothing else.
package pvpd_pkg;

	localparam int unsigned CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VIDEO_MODE   = 1'b0,
		CFG_PSEUDO_COLOR = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		KIND_BLACK,
		KIND_TWO,
		KIND_FOUR,
		KIND_DIRECT,
		KIND_DIRECT_GREY
	} kind_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	typedef struct packed {
		kind_t      kind;
		rgb_t       pal0;
		rgb_t       pal1;
		logic [7:0] plane0;
		logic [7:0] plane1;
		logic [7:0] plane2;
		logic [7:0] plane3;
	} entry_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} fifo_stat_t;

	typedef struct packed {
		logic pop;
		logic busy;
	} back_ctl_t;

	localparam logic [7:0] LVL_NORMAL = 8'hbf;
	localparam logic [7:0] LVL_BRIGHT = 8'hff;
	localparam logic [7:0] LVL_GREY   = 8'h40;
	localparam logic [7:0] LVL_FOUR   = 8'hc0;

	localparam rgb_t RGB_BLACK      = '{blue: 8'h00, green: 8'h00, red: 8'h00};
	localparam rgb_t RGB_MONO_GREEN = '{blue: 8'h00, green: 8'hff, red: 8'h00};
	localparam rgb_t RGB_MONO_BG    = '{blue: 8'hc8, green: 8'hb4, red: 8'h28};
	localparam rgb_t RGB_MONO_FG    = '{blue: 8'h32, green: 8'hfa, red: 8'hfa};
	localparam rgb_t RGB_FOUR_GREY  = '{blue: LVL_FOUR, green: LVL_FOUR, red: LVL_FOUR};
	localparam rgb_t RGB_FOUR_RED   = '{blue: 8'h00, green: 8'h00, red: LVL_FOUR};
	localparam rgb_t RGB_FOUR_GREEN = '{blue: 8'h00, green: LVL_FOUR, red: 8'h00};
	localparam rgb_t RGB_FOUR_BLUE  = '{blue: LVL_FOUR, green: 8'h00, red: 8'h00};

	// One attribute nibble: intensity, red, green, blue from the top bit down.
	function automatic rgb_t attr_rgb(input logic [3:0] nib);
		logic [7:0] lvl;
		rgb_t       c;
		lvl = nib[3] ? LVL_BRIGHT : LVL_NORMAL;
		c.red   = nib[2] ? lvl : 8'h00;
		c.green = nib[1] ? lvl : 8'h00;
		c.blue  = nib[0] ? lvl : 8'h00;
		return c;
	endfunction

	// Colour of one pixel; sel is the bit position within the plane bytes.
	function automatic rgb_t pixel_rgb(input entry_t e, input logic [2:0] sel);
		logic b0, b1, b2, b3;
		rgb_t c;
		b0 = e.plane0[sel];
		b1 = e.plane1[sel];
		b2 = e.plane2[sel];
		b3 = e.plane3[sel];
		c  = RGB_BLACK;
		case (e.kind)
			KIND_TWO: begin
				c = b0 ? e.pal1 : e.pal0;
			end
			KIND_FOUR: begin
				case ({b0, b2})
					2'b00:   c = e.pal0;
					2'b01:   c = RGB_FOUR_RED;
					2'b10:   c = RGB_FOUR_GREEN;
					default: c = RGB_FOUR_BLUE;
				endcase
			end
			KIND_DIRECT, KIND_DIRECT_GREY: begin
				c.red   = b0 ? LVL_NORMAL : 8'h00;
				c.green = b1 ? LVL_NORMAL : 8'h00;
				c.blue  = b2 ? LVL_NORMAL : 8'h00;
				if (e.kind == KIND_DIRECT_GREY && b3) begin
					c.red   = c.red | LVL_GREY;
					c.green = c.green | LVL_GREY;
					c.blue  = c.blue | LVL_GREY;
				end
			end
			default: begin
				c = RGB_BLACK;
			end
		endcase
		return c;
	endfunction

endpackage

// File: src/pvpd_front.sv
// Front end of the planar video pixel decoder: configuration registers and the input stage.
// Classifies each column item by video mode and builds its palette; uses pvpd_pkg.
module pvpd_front
	import pvpd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,   // plane0_byte, plane1_byte, plane2_byte, plane3_byte
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output logic                 ent_valid,
	input  logic                 ent_ready,
	output entry_t               ent
);

	logic [4:0] video_mode_q;
	logic [7:0] pseudo_color_q;
	logic       valid_s1;
	entry_t     entry_s1;
	entry_t     entry_d;
	logic [7:0] attr;
	logic       take;

	assign s_tready  = !valid_s1 || ent_ready;
	assign take      = s_tvalid && s_tready;
	assign ent_valid = valid_s1;
	assign ent       = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			video_mode_q   <= '0;
			pseudo_color_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_VIDEO_MODE:   video_mode_q   <= cfg_data[4:0];
				CFG_PSEUDO_COLOR: pseudo_color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		entry_d.plane0 = s_tdata[7:0];
		entry_d.plane1 = s_tdata[15:8];
		entry_d.plane2 = s_tdata[23:16];
		entry_d.plane3 = s_tdata[31:24];
		entry_d.kind   = KIND_BLACK;
		entry_d.pal0   = RGB_BLACK;
		entry_d.pal1   = RGB_BLACK;
		attr = (video_mode_q inside {5'd14, 5'd15}) ? pseudo_color_q : s_tdata[23:16];
		if (video_mode_q[4]) begin
			entry_d.kind = video_mode_q[2] ? KIND_DIRECT_GREY : KIND_DIRECT;
		end else begin
			case (video_mode_q) inside
				5'd0: begin
					entry_d.kind = KIND_TWO;
					entry_d.pal1 = RGB_MONO_GREEN;
				end
				5'd1: begin
					entry_d.kind = KIND_TWO;
					entry_d.pal0 = RGB_MONO_BG;
					entry_d.pal1 = RGB_MONO_FG;
				end
				5'd4, 5'd5: begin
					entry_d.kind = KIND_FOUR;
					entry_d.pal0 = video_mode_q[0] ? RGB_FOUR_GREY : RGB_BLACK;
				end
				5'd6, 5'd7, 5'd14, 5'd15: begin
					entry_d.kind = KIND_TWO;
					entry_d.pal0 = attr_rgb(attr[7:4]);
					entry_d.pal1 = attr_rgb(attr[3:0]);
				end
				default: begin
					entry_d.kind = KIND_BLACK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			entry_s1 <= entry_d;
		end
	end

endmodule

// File: src/pvpd_fifo.sv
// Short queue of classified column items between the front and back ends.
// Uses entry and status types from pvpd_pkg.
module pvpd_fifo
	import pvpd_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  entry_t     in_entry,
	input  logic       pop,
	output entry_t     out_entry,
	output fifo_stat_t stat
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;

	assign stat.full      = (count_q == CW'(DEPTH));
	assign stat.not_empty = (count_q != '0);
	assign in_ready       = !stat.full;
	assign push           = in_valid && !stat.full;
	assign out_entry      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_entry;
		end
	end

endmodule

// File: src/pvpd_back.sv
// Back end of the planar video pixel decoder: serialises one column item into eight pixels.
// Holds the output register of the pixel stream; uses pvpd_pkg.
module pvpd_back
	import pvpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  fifo_stat_t fifo_stat,
	input  entry_t     in_entry,
	output back_ctl_t  ctl,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [23:0] m_tdata,   // red, green, blue
	output logic       m_tlast
);

	entry_t     cur_q;
	logic [2:0] cnt_q;
	logic       busy_q;
	logic       valid_q;
	rgb_t       data_q;
	logic       last_q;
	logic       advance;
	logic       last_beat;

	assign advance   = busy_q && (!valid_q || m_tready);
	assign last_beat = (cnt_q == 3'd7);
	assign ctl.pop   = fifo_stat.not_empty && (!busy_q || (advance && last_beat));
	assign ctl.busy  = busy_q;
	assign m_tvalid  = valid_q;
	assign m_tdata   = data_q;
	assign m_tlast   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_beat) begin
					busy_q <= 1'b0;
				end
			end
			if (ctl.pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
			if (advance) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			cur_q <= in_entry;
		end
		if (advance) begin
			data_q <= pixel_rgb(cur_q, ~cnt_q);
			last_q <= last_beat;
		end
	end

endmodule

// File: src/planar_video_pixel_decoder.sv
// Top level of the planar video pixel decoder: front end, item queue and pixel serialiser.
// Depends on pvpd_pkg, pvpd_front, pvpd_fifo and pvpd_back.
//
// Each transaction on the slave side carries one byte of each of four video planes and
// produces eight RGB pixels on the master side, leftmost (bit 7) first, with tlast on the
// eighth. The pixel serialiser emits one pixel per clock while m_tready is high, and items
// follow back to back while the queue holds them; an accepted item passes the front end
// register, the item queue, the serialiser's item register and its output register. The
// video mode and pseudo colour are sampled when an item is accepted, so they should be
// written only while no items are in flight. The configuration port is always ready.
module planar_video_pixel_decoder
	import pvpd_pkg::*;
#(
	parameter int unsigned FIFO_DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,   // plane0_byte, plane1_byte, plane2_byte, plane3_byte
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,   // red, green, blue
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	logic       ent_valid;
	logic       ent_ready;
	entry_t     ent;
	entry_t     fifo_entry;
	fifo_stat_t fifo_stat;
	back_ctl_t  back_ctl;

	assign cfg_ready = 1'b1;

	pvpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ent_valid (ent_valid),
		.ent_ready (ent_ready),
		.ent       (ent)
	);

	pvpd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ent_valid),
		.in_ready  (ent_ready),
		.in_entry  (ent),
		.pop       (back_ctl.pop),
		.out_entry (fifo_entry),
		.stat      (fifo_stat)
	);

	pvpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fifo_stat (fifo_stat),
		.in_entry  (fifo_entry),
		.ctl       (back_ctl),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// The serialiser never takes an item from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		back_ctl.pop |-> fifo_stat.not_empty)
		else $error("pop from an empty item queue");

	// A stalled output must not let the serialiser move on to another pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		back_ctl.busy && m_tvalid && !m_tready |=> back_ctl.busy && $stable(m_tdata))
		else $error("serialiser advanced while the output was stalled");

	// An item that the full queue cannot take is held unchanged by the front end.
	assert property (@(posedge clk) disable iff (!arst_n)
		ent_valid && fifo_stat.full && !back_ctl.pop |=> ent_valid && $stable(ent))
		else $error("front end item lost while the queue was full");

endmodule

// File: tb/sv/planar_video_pixel_decoder_test.sv
// Self-checking testbench for planar_video_pixel_decoder: directed table, then random phases.
// Depends on pvpd_pkg and the decoder RTL; predicts each pixel from its own mode decoder or the table colour.
module planar_video_pixel_decoder_test;
	import pvpd_pkg::*;

	localparam logic [4:0] MODE_MONO_GREEN   = 5'd0;
	localparam logic [4:0] MODE_MONO         = 5'd1;
	localparam logic [4:0] MODE_BLANK_A      = 5'd2;
	localparam logic [4:0] MODE_BLANK_B      = 5'd3;
	localparam logic [4:0] MODE_FOUR         = 5'd4;
	localparam logic [4:0] MODE_FOUR_GREY    = 5'd5;
	localparam logic [4:0] MODE_ATTR_A       = 5'd6;
	localparam logic [4:0] MODE_ATTR_B       = 5'd7;
	localparam logic [4:0] MODE_UNDEF_LO     = 5'd8;
	localparam logic [4:0] MODE_UNDEF_HI     = 5'd13;
	localparam logic [4:0] MODE_PSEUDO_A     = 5'd14;
	localparam logic [4:0] MODE_PSEUDO_B     = 5'd15;
	localparam logic [4:0] MODE_DIRECT       = 5'd16;
	localparam logic [4:0] MODE_DIRECT_GREY  = 5'd20;
	localparam logic [4:0] MODE_DIRECT_PLAIN = 5'd27;
	localparam logic [4:0] MODE_DIRECT_TOP   = 5'd31;

	localparam int RANDOM_COLUMNS = 280;
	localparam int SETTLE_CYCLES  = 6;
	localparam int DRAIN_CYCLES   = 16;
	localparam int LONG_HOLD      = 64;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PRINT_LIMIT    = 40;

	typedef enum logic {
		ROW_COLUMN,
		ROW_REG
	} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		cfg_idx_t   reg_idx;
		logic [7:0] reg_val;
		logic [31:0] planes;
		logic       typed;
		rgb_t       colour;
	} stim_row_t;

	typedef struct {
		rgb_t colour;
		logic last;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_idx_t    cfg_index = CFG_VIDEO_MODE;
	logic [7:0]  cfg_data = '0;

	stim_row_t   stim_table[$];
	pixel_t      pending_pixels[$];
	logic [4:0]  mode_q = '0;
	logic [7:0]  pseudo_q = '0;
	logic [31:0] modes_seen = '0;
	logic        calm = 1'b0;
	logic        hold_request = 1'b0;
	int          fail_count = 0;
	int          columns_sent = 0;
	int          pixels_checked = 0;
	int          reg_writes = 0;
	int          quiet_cycles = 0;
	pixel_t      want;
	rgb_t        got;

	planar_video_pixel_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic rgb_t colour_of(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		rgb_t c;
		c.red = r;
		c.green = g;
		c.blue = b;
		return c;
	endfunction

	function automatic logic [31:0] column(input logic [7:0] p0, input logic [7:0] p1,
			input logic [7:0] p2, input logic [7:0] p3);
		return {p3, p2, p1, p0};
	endfunction

	function automatic void add_reg(input cfg_idx_t idx, input logic [7:0] val);
		stim_row_t row;
		row.kind = ROW_REG;
		row.reg_idx = idx;
		row.reg_val = val;
		row.planes = '0;
		row.typed = 1'b0;
		row.colour = colour_of(8'h00, 8'h00, 8'h00);
		stim_table.push_back(row);
	endfunction

	function automatic void add_solid(input logic [31:0] planes, input logic typed,
			input rgb_t colour);
		stim_row_t row;
		row.kind = ROW_COLUMN;
		row.reg_idx = CFG_VIDEO_MODE;
		row.reg_val = '0;
		row.planes = planes;
		row.typed = typed;
		row.colour = colour;
		stim_table.push_back(row);
	endfunction

	// An attribute nibble is intensity, red, green, blue from the top bit down.
	function automatic rgb_t nibble_colour(input logic [3:0] nib);
		logic [7:0] on;
		on = nib[3] ? 8'hff : 8'hbf;
		return colour_of(nib[2] ? on : 8'h00, nib[1] ? on : 8'h00, nib[0] ? on : 8'h00);
	endfunction

	function automatic rgb_t decode_pixel(input logic [4:0] m, input logic [7:0] attr,
			input logic b0, input logic b1, input logic b2, input logic b3);
		logic [7:0] grey;
		if (m >= MODE_DIRECT) begin
			grey = (m[2] && b3) ? 8'h40 : 8'h00;
			return colour_of((b0 ? 8'hbf : 8'h00) | grey, (b1 ? 8'hbf : 8'h00) | grey,
				(b2 ? 8'hbf : 8'h00) | grey);
		end
		case (m)
			MODE_MONO_GREEN: begin
				return b0 ? colour_of(8'h00, 8'hff, 8'h00) : colour_of(8'h00, 8'h00, 8'h00);
			end
			MODE_MONO: begin
				return b0 ? colour_of(8'hfa, 8'hfa, 8'h32) : colour_of(8'h28, 8'hb4, 8'hc8);
			end
			MODE_FOUR, MODE_FOUR_GREY: begin
				case ({b0, b2})
					2'b00: return (m == MODE_FOUR_GREY) ? colour_of(8'hc0, 8'hc0, 8'hc0)
						: colour_of(8'h00, 8'h00, 8'h00);
					2'b01: return colour_of(8'hc0, 8'h00, 8'h00);
					2'b10: return colour_of(8'h00, 8'hc0, 8'h00);
					default: return colour_of(8'h00, 8'h00, 8'hc0);
				endcase
			end
			MODE_ATTR_A, MODE_ATTR_B, MODE_PSEUDO_A, MODE_PSEUDO_B: begin
				return nibble_colour(b0 ? attr[3:0] : attr[7:4]);
			end
			default: begin
				return colour_of(8'h00, 8'h00, 8'h00);
			end
		endcase
	endfunction

	function automatic void decode_column(input logic [31:0] planes);
		logic [7:0] attr;
		pixel_t     px;
		attr = (mode_q == MODE_PSEUDO_A || mode_q == MODE_PSEUDO_B) ? pseudo_q : planes[23:16];
		for (int k = 7; k >= 0; k--) begin
			px.colour = decode_pixel(mode_q, attr, planes[k], planes[8 + k], attr[k],
				planes[24 + k]);
			px.last = (k == 0);
			pending_pixels.push_back(px);
		end
	endfunction

	task automatic report_mismatch(input string what);
		if (fail_count < PRINT_LIMIT) begin
			$display("mismatch at %0t, pixel %0d: %s", $time, pixels_checked, what);
		end
		fail_count++;
	endtask

	task automatic send_column(input logic [31:0] planes, input logic typed, input rgb_t colour);
		pixel_t px;
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= planes;
		do @(posedge clk); while (!s_tready);
		if (typed) begin
			for (int k = 0; k < 8; k++) begin
				px.colour = colour;
				px.last = (k == 7);
				pending_pixels.push_back(px);
			end
		end else begin
			decode_column(planes);
		end
		modes_seen[mode_q] = 1'b1;
		columns_sent++;
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_VIDEO_MODE) begin
			mode_q = val[4:0];
		end else begin
			pseudo_q = val;
		end
		reg_writes++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("pixel arrived with nothing expected");
			end else begin
				want = pending_pixels.pop_front();
				got = m_tdata;
				if (got.red !== want.colour.red) begin
					report_mismatch($sformatf("red %02h, expected %02h", got.red,
						want.colour.red));
				end
				if (got.green !== want.colour.green) begin
					report_mismatch($sformatf("green %02h, expected %02h", got.green,
						want.colour.green));
				end
				if (got.blue !== want.colour.blue) begin
					report_mismatch($sformatf("blue %02h, expected %02h", got.blue,
						want.colour.blue));
				end
				if (m_tlast !== want.last) begin
					report_mismatch($sformatf("tlast %b, expected %b", m_tlast, want.last));
				end
			end
			pixels_checked++;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	// The sink stalls in short random bursts, and once for a long stretch so that the
	// decoder fills up and pushes back on the source.
	initial begin : sink_ctl
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				m_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		logic       prev_reg;
		logic [4:0] mode;
		logic [7:0] val;
		logic [7:0] p [4];
		int         phase;
		int         rand_done;
		int         phase_len;
		int         modes_count;

		add_solid(column(8'h00, 8'h00, 8'h00, 8'h00), 1'b1, colour_of(8'h00, 8'h00, 8'h00));
		add_solid(column(8'hff, 8'h00, 8'h00, 8'h00), 1'b1, colour_of(8'h00, 8'hff, 8'h00));
		add_solid(column(8'ha5, 8'h3c, 8'hf0, 8'h0f), 1'b0, colour_of(8'h00, 8'h00, 8'h00));
		add_reg(CFG_VIDEO_MODE, 8'(MODE_MONO));
		add_solid(column(8'h00, 8'hff, 8'hff, 8'hff), 1'b1, colour_of(8'h28, 8'hb4, 8'hc8));
		add_solid(column(8'hff, 8'h00, 8'h00, 8'h00), 1'b1, colour_of(8'hfa, 8'hfa, 8'h32));
		add_reg(CFG_VIDEO_MODE, 8'(MODE_BLANK_A));
		add_solid(column(8'hff, 8'hff, 8'hff, 8'hff), 1'b1, colour_of(8'h00, 8'h00, 8'h00));
		add_reg(CFG_VIDEO_MODE, 8'(MODE_BLANK_B));
		add_solid(column(8'hff, 8'hff, 8'hff, 8'hff), 1'b1, colour_of(8'h00, 8'h00, 8'h00));
		add_reg(CFG_VIDEO_MODE, 8'(MODE_FOUR));
		add_solid(column(8'hcc, 8'hff, 8'haa, 8'h00), 1'b0, colour_of(8'h00, 8'h00, 8'h00));
		add_solid(column(8'h00, 8'hff, 8'h00, 8'hff), 1'b1, colour_of(8'h00, 8'h00, 8'h00));
		add_reg(CFG_VIDEO_MODE, 8'(MODE_FOUR_GREY));
		add_solid(column(8'h00, 8'h00, 8'h00, 8'h00), 1'b1, colour_of(8'hc0, 8'hc0, 8'hc0));
		add_solid(column(8'hff, 8'h00, 8'hff, 8'h00), 1'b1, colour_of(8'h00, 8'h00, 8'hc0));
		add_reg(CFG_VIDEO_MODE, 8'(MODE_ATTR_A));
		add_solid(column(8'hf0, 8'h00, 8'h5e, 8'h00), 1'b0, colour_of(8'h00, 8'h00, 8'h00));
		add_solid(column(8'hff, 8'h00, 8'hff, 8'h00), 1'b1, colour_of(8'hff, 8'hff, 8'hff));
		add_reg(CFG_VIDEO_MODE, 8'(MODE_ATTR_B));
		add_solid(column(8'h96, 8'hff, 8'h7b, 8'hff), 1'b0, colour_of(8'h00, 8'h00, 8'h00));
		add_reg(CFG_VIDEO_MODE, 8'(MODE_UNDEF_LO));
		add_solid(column(8'hff, 8'hff, 8'hff, 8'hff), 1'b1, colour_of(8'h00, 8'h00, 8'h00));
		add_reg(CFG_VIDEO_MODE, 8'(MODE_UNDEF_HI));
		add_solid(column(8'hff, 8'hff, 8'hff, 8'hff), 1'b1, colour_of(8'h00, 8'h00, 8'h00));
		// The pseudo colour still holds its reset value here, so both colours are black.
		add_reg(CFG_VIDEO_MODE, 8'(MODE_PSEUDO_A));
		add_solid(column(8'hff, 8'h00, 8'hff, 8'h00), 1'b1, colour_of(8'h00, 8'h00, 8'h00));
		add_reg(CFG_PSEUDO_COLOR, 8'hf0);
		add_solid(column(8'h00, 8'h00, 8'h00, 8'h00), 1'b1, colour_of(8'hff, 8'hff, 8'hff));
		add_reg(CFG_PSEUDO_COLOR, 8'h3c);
		add_reg(CFG_VIDEO_MODE, 8'(MODE_PSEUDO_B));
		add_solid(column(8'h69, 8'h00, 8'ha5, 8'h00), 1'b0, colour_of(8'h00, 8'h00, 8'h00));
		add_reg(CFG_VIDEO_MODE, 8'(MODE_DIRECT));
		add_solid(column(8'hff, 8'hff, 8'hff, 8'hff), 1'b1, colour_of(8'hbf, 8'hbf, 8'hbf));
		add_reg(CFG_VIDEO_MODE, 8'(MODE_DIRECT_GREY));
		add_solid(column(8'hff, 8'hff, 8'hff, 8'hff), 1'b1, colour_of(8'hff, 8'hff, 8'hff));
		add_solid(column(8'h00, 8'h00, 8'h00, 8'hff), 1'b1, colour_of(8'h40, 8'h40, 8'h40));
		add_reg(CFG_VIDEO_MODE, 8'(MODE_DIRECT_TOP));
		add_solid(column(8'he1, 8'h4b, 8'hd2, 8'h87), 1'b0, colour_of(8'h00, 8'h00, 8'h00));
		add_reg(CFG_VIDEO_MODE, 8'(MODE_DIRECT_PLAIN));
		add_solid(column(8'h00, 8'h00, 8'h00, 8'hff), 1'b1, colour_of(8'h00, 8'h00, 8'h00));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		prev_reg = 1'b0;
		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_REG) begin
				if (!prev_reg) begin
					wait_idle();
				end
				write_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
				prev_reg = 1'b1;
			end else begin
				if (prev_reg) begin
					cfg_valid <= 1'b0;
				end
				send_column(stim_table[i].planes, stim_table[i].typed, stim_table[i].colour);
				prev_reg = 1'b0;
			end
		end

		phase = 0;
		rand_done = 0;
		while (rand_done < RANDOM_COLUMNS) begin
			wait_idle();
			if (phase == 0) begin
				mode = MODE_DIRECT_TOP;
			end else if (phase == 1) begin
				mode = MODE_MONO_GREEN;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: begin
						case ($urandom_range(0, 7))
							0: mode = MODE_MONO_GREEN;
							1: mode = MODE_MONO;
							2: mode = MODE_FOUR;
							3: mode = MODE_FOUR_GREY;
							4: mode = MODE_ATTR_A;
							5: mode = MODE_ATTR_B;
							6: mode = MODE_PSEUDO_A;
							default: mode = MODE_PSEUDO_B;
						endcase
					end
					6, 7, 8: begin
						mode = MODE_DIRECT | 5'($urandom_range(0, 15));
					end
					default: begin
						mode = $urandom_range(0, 1) ? 5'($urandom_range(MODE_BLANK_A, MODE_BLANK_B))
							: 5'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI));
					end
				endcase
			end
			// The bits above the mode field are don't-care and are randomised.
			val = 8'($urandom);
			val[4:0] = mode;
			if (phase < 2) begin
				write_reg(CFG_VIDEO_MODE, val);
				write_reg(CFG_PSEUDO_COLOR, (phase == 0) ? 8'hff : 8'h00);
			end else if ($urandom_range(0, 1)) begin
				write_reg(CFG_PSEUDO_COLOR, 8'($urandom));
				write_reg(CFG_VIDEO_MODE, val);
			end else begin
				write_reg(CFG_VIDEO_MODE, val);
				if ($urandom_range(0, 1)) begin
					write_reg(CFG_PSEUDO_COLOR, 8'($urandom));
				end
			end
			cfg_valid <= 1'b0;
			if (phase == 2) begin
				hold_request = 1'b1;
			end
			phase_len = $urandom_range(10, 30);
			for (int n = 0; n < phase_len && rand_done < RANDOM_COLUMNS; n++) begin
				calm = (rand_done >= RANDOM_COLUMNS - 40);
				for (int j = 0; j < 4; j++) begin
					case ($urandom_range(0, 7))
						0: p[j] = 8'h00;
						1: p[j] = 8'hff;
						default: p[j] = 8'($urandom);
					endcase
				end
				send_column(column(p[0], p[1], p[2], p[3]), 1'b0, colour_of(8'h00, 8'h00, 8'h00));
				rand_done++;
			end
			phase++;
		end

		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		modes_count = $countones(modes_seen);
		$display("covered %0d columns and %0d pixels over %0d register writes and %0d phases",
			columns_sent, pixels_checked, reg_writes, phase);
		$display("%0d of 32 video modes were exercised; %0d mismatches", modes_count, fail_count);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
